>>> rtl/core/dsam_pkg.sv
// ----------------------------------------------------------------------------
// dsam_pkg
// Shared constants for the decimal shift-add multiplier.
// ----------------------------------------------------------------------------
package dsam_pkg;

    // Default number of BCD digits per operand
    localparam int DIGITS_DEF = 11;

    // Width of one packed BCD digit
    localparam int DIGIT_W = 4;

    // Decimal radix and largest plain decimal digit
    localparam int BCD_BASE = 10;
    localparam int BCD_MAX  = 9;

    // Multiple held in the precomputed triple register
    localparam int TRIPLE_STEP = 3;

endpackage

>>> rtl/core/dsam_req_if.sv
// ----------------------------------------------------------------------------
// dsam_req_if
// Request channel: multiplicand and multiplier beat with valid/ready.
// ----------------------------------------------------------------------------
interface dsam_req_if #(
    parameter int W = dsam_pkg::DIGITS_DEF * dsam_pkg::DIGIT_W
);
    logic         valid;
    logic         ready;
    logic [W-1:0] multiplicand;
    logic [W-1:0] multiplier;

    modport source (output valid, output multiplicand, output multiplier, input ready);
    modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

>>> rtl/core/dsam_rsp_if.sv
// ----------------------------------------------------------------------------
// dsam_rsp_if
// Response channel: high and low product halves with valid/ready.
// ----------------------------------------------------------------------------
interface dsam_rsp_if #(
    parameter int W = dsam_pkg::DIGITS_DEF * dsam_pkg::DIGIT_W
);
    logic         valid;
    logic         ready;
    logic [W-1:0] product_high;
    logic [W-1:0] product_low;

    modport source (output valid, output product_high, output product_low, input ready);
    modport sink   (input valid, input product_high, input product_low, output ready);
endinterface

>>> rtl/core/dsam_bcd_adder.sv
// ----------------------------------------------------------------------------
// dsam_bcd_adder
// Shared packed-BCD adder, ripple carry across digits, top carry dropped.
// ----------------------------------------------------------------------------
module dsam_bcd_adder #(
    parameter int NDIG = dsam_pkg::DIGITS_DEF + 1
) (
    input  logic [NDIG*dsam_pkg::DIGIT_W-1:0] a,
    input  logic [NDIG*dsam_pkg::DIGIT_W-1:0] b,
    output logic [NDIG*dsam_pkg::DIGIT_W-1:0] sum
);
    localparam int DW = dsam_pkg::DIGIT_W;

    logic [NDIG:0] carry;

    assign carry[0] = 1'b0;

    // One digit cell per position: correct by subtracting ten above nine
    for (genvar k = 0; k < NDIG; k++) begin : g_digit
        logic [DW:0] raw;
        logic [DW:0] adj;

        always_comb
        begin
            raw = {1'b0, a[k*DW +: DW]} + {1'b0, b[k*DW +: DW]} + {{DW{1'b0}}, carry[k]};
            adj = raw - (DW+1)'(dsam_pkg::BCD_BASE);
            if (raw > (DW+1)'(dsam_pkg::BCD_MAX))
            begin
                sum[k*DW +: DW] = adj[DW-1:0];
                carry[k+1]      = 1'b1;
            end
            else
            begin
                sum[k*DW +: DW] = raw[DW-1:0];
                carry[k+1]      = 1'b0;
            end
        end
    end
endmodule

>>> rtl/core/decimal_shift_add_multiplier.sv
// ----------------------------------------------------------------------------
// decimal_shift_add_multiplier
// Sequence: accept in IDLE, add the multiplicand three times to form the triple, then per
//   multiplier digit d add the triple d/3 times and the multiplicand d%3 times, then shift
//   one digit right; the result then waits in DONE until it is taken.
// Throughput: one item at a time; every addition goes through one BCD adder.
// Reset: rst_n clears the sequencer to idle; data registers are not reset.
// ----------------------------------------------------------------------------
module decimal_shift_add_multiplier #(
    parameter int DIGITS = dsam_pkg::DIGITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dsam_req_if.sink   req,
    dsam_rsp_if.source rsp
);
    localparam int NW     = dsam_pkg::DIGIT_W;
    localparam int DW     = DIGITS * NW;
    localparam int RW     = (DIGITS + 1) * NW;
    localparam int CNT_W  = $clog2(DIGITS);
    localparam int TADD_W = $clog2(dsam_pkg::TRIPLE_STEP);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_TRIPLE = 4'b0010,
        S_DIGIT  = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t            state_reg,  state_next;
    logic [TADD_W-1:0] tadd_reg,   tadd_next;
    logic [CNT_W-1:0]  digit_reg,  digit_next;

    logic [RW-1:0]     single_reg, single_next;
    logic [RW-1:0]     triple_reg, triple_next;
    logic [RW-1:0]     acc_reg,    acc_next;
    logic [DW-1:0]     mplr_reg,   mplr_next;
    logic [DW-1:0]     low_reg,    low_next;
    logic [NW-1:0]     dcnt_reg,   dcnt_next;

    logic [RW-1:0]     addend;
    logic [RW-1:0]     sum;
    logic              use_triple;

    // Pick the multiple for this addition
    assign use_triple = (state_reg == S_DIGIT) && (dcnt_reg >= NW'(dsam_pkg::TRIPLE_STEP));
    assign addend     = use_triple ? triple_reg : single_reg;

    dsam_bcd_adder #(
        .NDIG (DIGITS + 1)
    ) u_adder (
        .a   (acc_reg),
        .b   (addend),
        .sum (sum)
    );

    // Sequencer and datapath next values
    always_comb
    begin
        state_next  = state_reg;
        tadd_next   = tadd_reg;
        digit_next  = digit_reg;
        single_next = single_reg;
        triple_next = triple_reg;
        acc_next    = acc_reg;
        mplr_next   = mplr_reg;
        low_next    = low_reg;
        dcnt_next   = dcnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    single_next = {{NW{1'b0}}, req.multiplicand};
                    mplr_next   = req.multiplier;
                    dcnt_next   = req.multiplier[NW-1:0];
                    acc_next    = '0;
                    tadd_next   = '0;
                    digit_next  = '0;
                    state_next  = S_TRIPLE;
                end
            end
            S_TRIPLE:
            begin
                // Add the multiplicand three times, then park the triple
                acc_next  = sum;
                tadd_next = tadd_reg + TADD_W'(1);
                if (tadd_reg == TADD_W'(dsam_pkg::TRIPLE_STEP - 1))
                begin
                    triple_next = sum;
                    acc_next    = '0;
                    state_next  = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (dcnt_reg != '0)
                begin
                    // Count the digit down by the multiple just added
                    acc_next  = sum;
                    dcnt_next = use_triple ? dcnt_reg - NW'(dsam_pkg::TRIPLE_STEP)
                                           : dcnt_reg - NW'(1);
                end
                else
                begin
                    // Shift one digit right, bottom digit into the low product
                    low_next   = {acc_reg[NW-1:0], low_reg[DW-1:NW]};
                    acc_next   = {{NW{1'b0}}, acc_reg[RW-1:NW]};
                    mplr_next  = {{NW{1'b0}}, mplr_reg[DW-1:NW]};
                    dcnt_next  = mplr_reg[2*NW-1:NW];
                    digit_next = digit_reg + CNT_W'(1);
                    if (digit_reg == CNT_W'(DIGITS - 1))
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tadd_reg  <= '0;
            digit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tadd_reg  <= tadd_next;
            digit_reg <= digit_next;
        end
    end

    // Data registers
    always_ff @(posedge clk)
    begin
        single_reg <= single_next;
        triple_reg <= triple_next;
        acc_reg    <= acc_next;
        mplr_reg   <= mplr_next;
        low_reg    <= low_next;
        dcnt_reg   <= dcnt_next;
    end

    // Drive the handshake and the held result
    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = (state_reg == S_DONE);
    assign rsp.product_high = acc_reg[DW-1:0];
    assign rsp.product_low  = low_reg;
endmodule

>>> rtl/core/dsam_checker.sv
// ----------------------------------------------------------------------------
// dsam_checker
// Port-level checks for the multiplier, attached to the top level by bind.
// ----------------------------------------------------------------------------
module dsam_checker #(
    parameter int DIGITS = dsam_pkg::DIGITS_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [DIGITS*dsam_pkg::DIGIT_W-1:0] product_high,
    input logic [DIGITS*dsam_pkg::DIGIT_W-1:0] product_low
);
    // Hold the result beat until it is taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat dropped before it was taken");

    // Keep the payload steady while stalled
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(product_high) && $stable(product_low))
        else $error("result payload changed while stalled");

    // Never take a new request while a result is pending
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request accepted while a result is pending");

    // Stay busy right after a request is accepted
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready && !rsp_valid)
        else $error("no multiply work after an accepted request");

    // Return to idle once the result has been taken
    a_reidle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready |=> req_ready && !rsp_valid)
        else $error("not idle after the result beat");
endmodule

bind decimal_shift_add_multiplier dsam_checker #(
    .DIGITS (DIGITS)
) u_dsam_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .product_high (rsp.product_high),
    .product_low  (rsp.product_low)
);
